### rtl/core/hbfd_pkg.sv
`timescale 1ns / 1ps

package hbfd_pkg;

   // Transaction kinds.
   localparam logic [1:0] KIND_POLL  = 2'd0;
   localparam logic [1:0] KIND_CPL   = 2'd1;
   localparam logic [1:0] KIND_DECAY = 2'd2;

   // Register indexes on the csr port.
   localparam logic [2:0] CSR_MY_ID          = 3'd0;
   localparam logic [2:0] CSR_PEER_MASK      = 3'd1;
   localparam logic [2:0] CSR_RETRY_INTERVAL = 3'd2;
   localparam logic [2:0] CSR_ATTEMPT_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_HISTORY_CAP    = 3'd4;

   localparam int ID_W     = 4;
   localparam int ID_SPACE = 16;
   localparam int VALUE_W  = 64;
   localparam int BYTE_W   = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [BYTE_W-1:0] SCORE_LIVE_MIN = 8'd2;
   localparam logic [BYTE_W-1:0] SCORE_STEP     = 8'd2;
   localparam logic [BYTE_W-1:0] FAIL_MAX       = 8'd255;
   localparam logic [BYTE_W-1:0] PHASE_ON       = 8'd1;

   typedef struct packed {
      logic load;
      logic apply_cpl;
      logic step;
      logic use_mod;
      logic mod_start;
      logic emit;
   } hbfd_cmd_type;

   typedef struct packed {
      logic need_mod;
      logic idx_last;
      logic mod_done;
      logic targets_le_one;
   } hbfd_sts_type;

endpackage

### rtl/core/heartbeat_failure_detector.sv
`timescale 1ns / 1ps

// Heartbeat failure detector with leader election. A transaction is taken when
// start is high and busy is low; its results follow on the rsp_ ports, one per
// cycle in consecutive cycles, each marked by rsp_valid for exactly one cycle,
// and the receiver cannot stall them, so it must take every result as it comes.
// rsp_last marks the final result of a transaction; busy falls in that cycle and
// the next transaction may be taken then. A completion passes through an apply
// state and an emit state to its result. A decay round walks one table slot per
// cycle across min(PEER_SLOTS, 16) slots. A poll round walks the same slots and
// then gives one result per polled peer; a present slot whose stored
// phase is at least twice the retry interval minus one (only after the interval
// was lowered) holds the walk while the serial remainder unit wraps its phase.
// The table resets to zero with the block. Configuration is written through
// csr_valid/csr_ready, which is always ready; write only while busy is low.
module heartbeat_failure_detector
   import hbfd_pkg::*;
#(
   parameter int PEER_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_kind,
   input  logic [ID_W-1:0]       req_peer_id,
   input  logic [VALUE_W-1:0]    req_counter_value,
   output logic                  rsp_valid,
   output logic                  rsp_read_valid,
   output logic [ID_W-1:0]       rsp_read_peer,
   output logic [ID_W-1:0]       rsp_leader,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   hbfd_cmd_type cmd;
   hbfd_sts_type sts;

   // Register writes land in any cycle; the user must keep writes to idle time.
   assign csr_ready = 1'b1;

   hbfd_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   hbfd_datapath #(
      .PEER_SLOTS (PEER_SLOTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_kind          (req_kind),
      .req_peer_id       (req_peer_id),
      .req_counter_value (req_counter_value),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_peer     (rsp_read_peer),
      .rsp_leader        (rsp_leader),
      .rsp_last          (rsp_last)
   );

   // An accepted transaction holds the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block did not go busy after accepting a transaction");

   // The block only returns to idle as the final result goes out.
   a_idle_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> (rsp_valid && rsp_last))
      else $error("block went idle without delivering its final result");

   // Results of one transaction come out back to back.
   a_results_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside the results of one transaction");

endmodule

### rtl/core/hbfd_rem.sv
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module hbfd_rem
   import hbfd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [BYTE_W:0]   dividend,
   input  logic [BYTE_W-1:0] divisor,
   output logic              done,
   output logic [BYTE_W-1:0] remainder
);

   localparam int DVD_W = BYTE_W + 1;
   localparam int CNT_W = $clog2(DVD_W);

   logic              run_ff;
   logic              done_ff;
   logic [BYTE_W-1:0] rem_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [BYTE_W-1:0] div_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [DVD_W-1:0]  trial;
   logic [DVD_W-1:0]  trial_sub;
   logic [BYTE_W-1:0] rem_in;

   always_comb begin
      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, div_ff};
      if (trial >= {1'b0, div_ff}) begin
         rem_in = trial_sub[BYTE_W-1:0];
      end else begin
         rem_in = trial[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dvd_ff <= dividend;
         div_ff <= divisor;
         cnt_ff <= CNT_W'(DVD_W - 1);
      end else if (run_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[DVD_W-2:0], 1'b0};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_done_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##(DVD_W + 1) done)
      else $error("remainder unit did not finish on time");

endmodule

### rtl/core/hbfd_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: accepts, applies or walks the slots, then emits results.
module hbfd_ctrl
   import hbfd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [1:0]   req_kind,
   input  hbfd_sts_type sts,
   output hbfd_cmd_type cmd,
   output logic         busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_MOD,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_kind == KIND_POLL || req_kind == KIND_DECAY) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            cmd.apply_cpl = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_SCAN: begin
            if (sts.need_mod) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_MOD;
            end else begin
               cmd.step = 1'b1;
               if (sts.idx_last) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MOD: begin
            if (sts.mod_done) begin
               cmd.step    = 1'b1;
               cmd.use_mod = 1'b1;
               state_in    = sts.idx_last ? ST_EMIT : ST_SCAN;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.targets_le_one) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

### rtl/core/hbfd_datapath.sv
`timescale 1ns / 1ps

// Liveness table, configuration registers, slot update logic and result register.
module hbfd_datapath
   import hbfd_pkg::*;
#(
   parameter int PEER_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  hbfd_cmd_type          cmd,
   output hbfd_sts_type          sts,
   input  logic [1:0]            req_kind,
   input  logic [ID_W-1:0]       req_peer_id,
   input  logic [VALUE_W-1:0]    req_counter_value,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   output logic                  rsp_read_valid,
   output logic [ID_W-1:0]       rsp_read_peer,
   output logic [ID_W-1:0]       rsp_leader,
   output logic                  rsp_last
);

   // Only ids below the id space can ever be present.
   localparam int ACTIVE_SLOTS = (PEER_SLOTS < ID_SPACE) ? PEER_SLOTS : ID_SPACE;
   localparam int IDX_W        = $clog2(ACTIVE_SLOTS);

   // Configuration.
   logic [ID_W-1:0]       my_id_ff;
   logic [ID_SPACE-1:0]   peer_mask_ff;
   logic [BYTE_W-1:0]     retry_interval_ff;
   logic [BYTE_W-1:0]     attempt_limit_ff;
   logic [BYTE_W-1:0]     history_cap_ff;

   // Liveness table.
   logic [VALUE_W-1:0]    last_value_ff  [ACTIVE_SLOTS];
   logic [BYTE_W-1:0]     fresh_score_ff [ACTIVE_SLOTS];
   logic [BYTE_W-1:0]     fail_count_ff  [ACTIVE_SLOTS];
   logic [BYTE_W-1:0]     retry_phase_ff [ACTIVE_SLOTS];

   // Transaction context.
   logic [1:0]            kind_ff;
   logic [ID_W-1:0]       pid_ff;
   logic [VALUE_W-1:0]    cval_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [ACTIVE_SLOTS-1:0] target_ff;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_read_valid_ff;
   logic [ID_W-1:0]       rsp_read_peer_ff;
   logic [ID_W-1:0]       rsp_leader_ff;
   logic                  rsp_last_ff;

   logic [ACTIVE_SLOTS-1:0] present_vec;
   logic [IDX_W-1:0]      addr;
   logic                  addr_present;
   logic                  pid_in_range;
   logic [BYTE_W-1:0]     cur_score;
   logic [BYTE_W-1:0]     cur_fail;
   logic [BYTE_W-1:0]     cur_phase;
   logic [BYTE_W-1:0]     period;
   logic [BYTE_W:0]       phase_inc;
   logic [BYTE_W:0]       period_x1;
   logic [BYTE_W:0]       period_x2;
   logic [BYTE_W:0]       phase_sub;
   logic                  fast_ok;
   logic [BYTE_W-1:0]     fast_phase;
   logic [BYTE_W-1:0]     phase_in;
   logic                  target_in;
   logic [BYTE_W-1:0]     decay_score_in;
   logic [BYTE_W-1:0]     decay_fail_in;
   logic [BYTE_W:0]       cpl_sum;
   logic [BYTE_W-1:0]     cpl_score_in;
   logic                  cpl_rise;
   logic                  mod_done;
   logic [BYTE_W-1:0]     mod_rem;
   logic                  leader_found;
   logic [ID_W-1:0]       leader_cand;
   logic [ID_W-1:0]       leader_now;
   logic [ID_W-1:0]       first_target;
   logic [ACTIVE_SLOTS-1:0] target_rest;

   always_comb begin
      for (int i = 0; i < ACTIVE_SLOTS; i++) begin
         present_vec[i] = peer_mask_ff[i] && (ID_W'(i) != my_id_ff);
      end
   end

   // One table address at a time: the completing peer or the scan slot.
   assign pid_in_range = ({1'b0, pid_ff} < (ID_W + 1)'(ACTIVE_SLOTS));
   assign addr         = (kind_ff == KIND_CPL) ? pid_ff[IDX_W-1:0] : idx_ff;
   assign addr_present = present_vec[addr] &&
                         ((kind_ff != KIND_CPL) || pid_in_range);

   assign cur_score = fresh_score_ff[addr];
   assign cur_fail  = fail_count_ff[addr];
   assign cur_phase = retry_phase_ff[addr];

   // Phase advance: compare-and-subtract when the phase is near the period,
   // otherwise the remainder unit finishes the job.
   always_comb begin
      period     = (retry_interval_ff == '0) ? BYTE_W'(1) : retry_interval_ff;
      phase_inc  = {1'b0, cur_phase} + (BYTE_W + 1)'(1);
      period_x1  = {1'b0, period};
      period_x2  = {period, 1'b0};
      phase_sub  = phase_inc - period_x1;
      fast_ok    = (phase_inc < period_x2);
      if (phase_inc < period_x1) begin
         fast_phase = phase_inc[BYTE_W-1:0];
      end else begin
         fast_phase = phase_sub[BYTE_W-1:0];
      end
      phase_in  = cmd.use_mod ? mod_rem : fast_phase;
      target_in = !((cur_fail > attempt_limit_ff) && (phase_in != PHASE_ON));
   end

   always_comb begin
      decay_score_in = (cur_score != '0) ? (cur_score - 1'b1) : cur_score;
      if (decay_score_in == '0 && cur_fail != FAIL_MAX) begin
         decay_fail_in = cur_fail + 1'b1;
      end else begin
         decay_fail_in = cur_fail;
      end
      cpl_sum = {1'b0, cur_score} + {1'b0, SCORE_STEP};
      if (cpl_sum > {1'b0, history_cap_ff}) begin
         cpl_score_in = history_cap_ff;
      end else begin
         cpl_score_in = cpl_sum[BYTE_W-1:0];
      end
      cpl_rise = (last_value_ff[addr] < cval_ff);
   end

   hbfd_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (phase_inc),
      .divisor   (period),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Leader: lowest live present peer; my_id if that peer is not below it.
   always_comb begin
      leader_found = 1'b0;
      leader_cand  = '0;
      for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
         if (present_vec[i] && fresh_score_ff[i] > SCORE_LIVE_MIN) begin
            leader_found = 1'b1;
            leader_cand  = ID_W'(i);
         end
      end
      leader_now = (leader_found && leader_cand < my_id_ff) ? leader_cand : my_id_ff;
   end

   always_comb begin
      first_target = '0;
      for (int i = ACTIVE_SLOTS - 1; i >= 0; i--) begin
         if (target_ff[i]) begin
            first_target = ID_W'(i);
         end
      end
      target_rest = target_ff & (target_ff - 1'b1);
   end

   always_comb begin
      sts.need_mod       = (kind_ff == KIND_POLL) && addr_present && !fast_ok;
      sts.idx_last       = (idx_ff == IDX_W'(ACTIVE_SLOTS - 1));
      sts.mod_done       = mod_done;
      sts.targets_le_one = (target_rest == '0);
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff          <= ID_W'(1);
         peer_mask_ff      <= '0;
         retry_interval_ff <= BYTE_W'(8);
         attempt_limit_ff  <= BYTE_W'(4);
         history_cap_ff    <= BYTE_W'(8);
      end else if (csr_write) begin
         case (csr_index)
            CSR_MY_ID:          my_id_ff          <= csr_data[ID_W-1:0];
            CSR_PEER_MASK:      peer_mask_ff      <= csr_data[ID_SPACE-1:0];
            CSR_RETRY_INTERVAL: retry_interval_ff <= csr_data[BYTE_W-1:0];
            CSR_ATTEMPT_LIMIT:  attempt_limit_ff  <= csr_data[BYTE_W-1:0];
            CSR_HISTORY_CAP:    history_cap_ff    <= csr_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Table and transaction context.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACTIVE_SLOTS; i++) begin
            last_value_ff[i]  <= '0;
            fresh_score_ff[i] <= '0;
            fail_count_ff[i]  <= '0;
            retry_phase_ff[i] <= '0;
         end
         kind_ff   <= KIND_POLL;
         idx_ff    <= '0;
         target_ff <= '0;
      end else begin
         if (cmd.load) begin
            kind_ff   <= req_kind;
            idx_ff    <= '0;
            target_ff <= '0;
         end
         if (cmd.apply_cpl && kind_ff == KIND_CPL && addr_present) begin
            if (cpl_rise) begin
               fresh_score_ff[addr] <= cpl_score_in;
               fail_count_ff[addr]  <= '0;
            end
            last_value_ff[addr] <= cval_ff;
         end
         if (cmd.step) begin
            idx_ff <= idx_ff + 1'b1;
            if (addr_present && kind_ff == KIND_POLL) begin
               retry_phase_ff[addr] <= phase_in;
               target_ff[addr]      <= target_in;
            end
            if (addr_present && kind_ff == KIND_DECAY) begin
               fresh_score_ff[addr] <= decay_score_in;
               fail_count_ff[addr]  <= decay_fail_in;
            end
         end
         if (cmd.emit) begin
            target_ff <= target_rest;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pid_ff  <= req_peer_id;
         cval_ff <= req_counter_value;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_read_valid_ff <= (target_ff != '0);
         rsp_read_peer_ff  <= first_target;
         rsp_leader_ff     <= leader_now;
         rsp_last_ff       <= (target_rest == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_read_peer  = rsp_read_peer_ff;
   assign rsp_leader     = rsp_leader_ff;
   assign rsp_last       = rsp_last_ff;

   a_null_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_read_valid_ff) |-> rsp_last_ff)
      else $error("result without a read target was not the final one");

endmodule

### tb/heartbeat_failure_detector_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the heartbeat failure detector. A directed table
// walks the corner cases first, then several randomized phases run under
// different register settings. Every accepted transaction is run through a
// local liveness-table predictor, and each result strobe is compared field by
// field with the oldest predicted result.
module heartbeat_failure_detector_tb;
   import hbfd_pkg::*;

   // Kind 3 is not decoded by the block; it must still answer with one result.
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam int STALL_LIMIT = 4000;  // cycles with no handshake of any kind
   localparam int TAIL_CYCLES = 250;   // covers the slowest poll round

   typedef struct packed {
      logic            read_valid;
      logic [ID_W-1:0] read_peer;
      logic [ID_W-1:0] leader;
      logic            last;
   } hb_result_type;

   // One line of the directed table. A line either rewrites all registers or
   // sends one transaction; typed lines carry a result that is obvious by eye.
   typedef struct packed {
      logic               set_regs;
      logic [ID_W-1:0]    my_id;
      logic [15:0]        mask;
      logic [7:0]         interval;
      logic [7:0]         limit;
      logic [7:0]         cap;
      logic [1:0]         kind;
      logic [ID_W-1:0]    peer;
      logic [VALUE_W-1:0] value;
      logic               typed;
      hb_result_type      want;
   } directed_row_type;

   localparam hb_result_type NO_RESULT = '0;
   localparam logic [VALUE_W-1:0] ALL_ONES = '1;

   localparam directed_row_type DIRECTED [23] = '{
      // Reset settings: my_id 1 and no peers, so every answer is a lone idle
      // result naming this node as leader.
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b1, '{1'b0, 4'd0, 4'd1, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd5, ALL_ONES,
        1'b1, '{1'b0, 4'd0, 4'd1, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_DECAY, 4'd0, 64'd0,
        1'b1, '{1'b0, 4'd0, 4'd1, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_UNUSED, 4'd9, ALL_ONES,
        1'b1, '{1'b0, 4'd0, 4'd1, 1'b1}},
      // All peers present, own bit ignored, zero retry interval acts as one.
      '{1'b1, 4'd15, 16'hFFFF, 8'd0, 8'd0, 8'd255, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd0, ALL_ONES,
        1'b1, '{1'b0, 4'd0, 4'd15, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd0, 64'd0,
        1'b1, '{1'b0, 4'd0, 4'd15, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd0, 64'd1,
        1'b1, '{1'b0, 4'd0, 4'd0, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd15, 64'd5,
        1'b1, '{1'b0, 4'd0, 4'd0, 1'b1}},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_DECAY, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_DECAY, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      // Cap lowered to 1 while peer 0 still holds a higher score.
      '{1'b1, 4'd1, 16'hAAAB, 8'd255, 8'd254, 8'd1, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd0, 64'd10,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd1, 64'd99,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd14,
        64'h8000_0000_0000_0000, 1'b0, NO_RESULT},
      '{1'b1, 4'd15, 16'hFFFF, 8'd2, 8'd0, 8'd3, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_DECAY, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_POLL, 4'd0, 64'd0,
        1'b0, NO_RESULT},
      '{1'b0, 4'd0, 16'h0000, 8'd0, 8'd0, 8'd0, KIND_CPL, 4'd7, 64'd3,
        1'b0, NO_RESULT}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_kind;
   logic [ID_W-1:0]       req_peer_id;
   logic [VALUE_W-1:0]    req_counter_value;
   logic                  rsp_valid;
   logic                  rsp_read_valid;
   logic [ID_W-1:0]       rsp_read_peer;
   logic [ID_W-1:0]       rsp_leader;
   logic                  rsp_last;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   heartbeat_failure_detector u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_peer_id       (req_peer_id),
      .req_counter_value (req_counter_value),
      .rsp_valid         (rsp_valid),
      .rsp_read_valid    (rsp_read_valid),
      .rsp_read_peer     (rsp_read_peer),
      .rsp_leader        (rsp_leader),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Local copy of the liveness table and of the registers.
   logic [VALUE_W-1:0] seen_counter [ID_SPACE];
   logic [BYTE_W-1:0]  score        [ID_SPACE];
   logic [BYTE_W-1:0]  fails        [ID_SPACE];
   logic [BYTE_W-1:0]  phase        [ID_SPACE];
   logic [ID_W-1:0]    cfg_my_id;
   logic [15:0]        cfg_mask;
   logic [BYTE_W-1:0]  cfg_interval;
   logic [BYTE_W-1:0]  cfg_limit;
   logic [BYTE_W-1:0]  cfg_cap;

   hb_result_type expected_results [$];  // predicted results not yet seen
   hb_result_type round_results    [$];  // scratch for one transaction

   int  results_predicted = 0;
   int  results_seen      = 0;  // advanced by nonblocking update in the monitor
   int  mismatches        = 0;
   int  stall_cycles      = 0;
   bit  gaps_on           = 1'b1;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // The own id never counts as a peer, whatever its mask bit says.
   function automatic bit peer_present(input int id);
      return id != int'(cfg_my_id) && cfg_mask[id] == 1'b1;
   endfunction

   // The first live present peer in id order wins only if it sits below my_id.
   function automatic logic [ID_W-1:0] elected_leader();
      for (int id = 0; id < ID_SPACE; id++) begin
         if (peer_present(id) && score[id] > SCORE_LIVE_MIN)
            return (id < int'(cfg_my_id)) ? ID_W'(id) : cfg_my_id;
      end
      return cfg_my_id;
   endfunction

   // Applies one transaction to the local table and leaves its results in
   // round_results, with the leader taken from the updated state.
   task automatic compute_round(input logic [1:0] kind, input logic [ID_W-1:0] peer,
                                input logic [VALUE_W-1:0] value);
      int              period;
      logic [8:0]      raised;
      logic [ID_W-1:0] winner;
      round_results.delete();
      case (kind)
         KIND_POLL: begin
            period = (cfg_interval == 0) ? 1 : int'(cfg_interval);
            for (int id = 0; id < ID_SPACE; id++) begin
               if (peer_present(id)) begin
                  phase[id] = BYTE_W'((int'(phase[id]) + 1) % period);
                  // Peers that failed too often are polled only on phase.
                  if (!(fails[id] > cfg_limit && phase[id] != PHASE_ON))
                     round_results.push_back('{1'b1, ID_W'(id), 4'd0, 1'b0});
               end
            end
         end
         KIND_CPL: begin
            if (peer_present(int'(peer))) begin
               if (seen_counter[peer] < value) begin
                  raised = {1'b0, score[peer]} + SCORE_STEP;
                  if (raised > {1'b0, cfg_cap})
                     raised = {1'b0, cfg_cap};
                  score[peer] = raised[BYTE_W-1:0];
                  fails[peer] = '0;
               end
               seen_counter[peer] = value;
            end
         end
         KIND_DECAY: begin
            for (int id = 0; id < ID_SPACE; id++) begin
               if (peer_present(id)) begin
                  if (score[id] > 0)
                     score[id] = score[id] - 1'b1;
                  if (score[id] == 0 && fails[id] != FAIL_MAX)
                     fails[id] = fails[id] + 1'b1;
               end
            end
         end
         default: ;
      endcase
      winner = elected_leader();
      foreach (round_results[i])
         round_results[i].leader = winner;
      if (round_results.size() == 0)
         round_results.push_back('{1'b0, 4'd0, winner, 1'b0});
      round_results[round_results.size() - 1].last = 1'b1;
   endtask

   // Mostly back-to-back, with an occasional longer pause.
   function automatic int idle_gap();
      int pick;
      if (!gaps_on)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      else if (pick < 85)
         return $urandom_range(1, 3);
      else if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Drops start and holds off until every predicted result has arrived and
   // the block has gone idle. It waits on the clock before its first check.
   task automatic wait_drained();
      start <= 1'b0;
      do
         @(posedge clock);
      while (results_seen < results_predicted || busy);
   endtask

   // Sends one transaction and records its predicted results on acceptance.
   // Start stays high after acceptance so that the next call can follow with
   // no gap.
   task automatic issue(input logic [1:0] kind, input logic [ID_W-1:0] peer,
                        input logic [VALUE_W-1:0] value, input logic typed,
                        input hb_result_type want);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_kind          <= kind;
      req_peer_id       <= peer;
      req_counter_value <= value;
      do
         @(posedge clock);
      while (busy);
      compute_round(kind, peer, value);
      if (typed) begin
         round_results.delete();
         round_results.push_back(want);
      end
      foreach (round_results[i])
         expected_results.push_back(round_results[i]);
      results_predicted += round_results.size();
   endtask

   // Rewrites every register once the block is idle. Valid stays high across
   // the five writes and drops after the last one.
   task automatic apply_settings(input logic [ID_W-1:0] my_id, input logic [15:0] mask,
                                 input logic [7:0] interval, input logic [7:0] limit,
                                 input logic [7:0] cap);
      logic [CSR_IDX_W-1:0]  regs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      regs = '{CSR_MY_ID, CSR_PEER_MASK, CSR_RETRY_INTERVAL, CSR_ATTEMPT_LIMIT,
               CSR_HISTORY_CAP};
      vals = '{CSR_DATA_W'(my_id), mask, CSR_DATA_W'(interval), CSR_DATA_W'(limit),
               CSR_DATA_W'(cap)};
      wait_drained();
      for (int i = 0; i < 5; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do
            @(posedge clock);
         while (!csr_ready);
         case (regs[i])
            CSR_MY_ID:          cfg_my_id    = vals[i][ID_W-1:0];
            CSR_PEER_MASK:      cfg_mask     = vals[i];
            CSR_RETRY_INTERVAL: cfg_interval = vals[i][BYTE_W-1:0];
            CSR_ATTEMPT_LIMIT:  cfg_limit    = vals[i][BYTE_W-1:0];
            CSR_HISTORY_CAP:    cfg_cap      = vals[i][BYTE_W-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // One random transaction. In a decay storm almost every transaction is a
   // decay round and only peers 0 to 3 ever see completions, so the other
   // peers run their failure counts toward saturation. Otherwise completions
   // mostly carry a counter just above the stored one, which lets scores climb
   // past the live threshold and keeps the leader moving.
   task automatic random_transaction(input bit storm);
      int                 pick;
      logic [1:0]         kind;
      logic [ID_W-1:0]    peer;
      logic [VALUE_W-1:0] value;
      pick = $urandom_range(0, 99);
      peer = ID_W'($urandom_range(0, ID_SPACE - 1));
      if (storm) begin
         kind = (pick < 88) ? KIND_DECAY : (pick < 95) ? KIND_POLL : KIND_CPL;
         peer = ID_W'($urandom_range(0, 3));
      end else begin
         kind = (pick < 22) ? KIND_POLL : (pick < 70) ? KIND_CPL :
                (pick < 95) ? KIND_DECAY : KIND_UNUSED;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
         value = seen_counter[peer] + VALUE_W'($urandom_range(1, 1000));
      else if (pick < 85)
         value = seen_counter[peer] - VALUE_W'($urandom_range(0, 3));
      else
         value = {$urandom, $urandom};
      if ($urandom_range(0, 99) < 3)
         gaps_on = ~gaps_on;
      // Now and then the sender waits for the block to empty completely.
      if ($urandom_range(0, 49) == 0)
         wait_drained();
      issue(kind, peer, value, 1'b0, NO_RESULT);
   endtask

   // Result monitor. Outputs are sampled at the edge that ends the strobe
   // cycle, before the block's own updates at that edge take effect.
   always @(posedge clock) begin
      hb_result_type got;
      hb_result_type want;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         got = '{rsp_read_valid, rsp_read_peer, rsp_leader, rsp_last};
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %p", got));
         end else begin
            want = expected_results.pop_front();
            if (got.read_valid !== want.read_valid)
               report_mismatch($sformatf("read_valid %b, expected %b",
                                         got.read_valid, want.read_valid));
            if (got.read_peer !== want.read_peer)
               report_mismatch($sformatf("read_peer %0d, expected %0d",
                                         got.read_peer, want.read_peer));
            if (got.leader !== want.leader)
               report_mismatch($sformatf("leader %0d, expected %0d",
                                         got.leader, want.leader));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
         end
      end
   end

   // Watchdog: any accepted transaction, result or register write restarts
   // the count. The slowest legal silence is a long sender gap followed by a
   // poll round that wraps every phase serially, well under the limit.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("heartbeat_failure_detector_tb failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      start             <= 1'b0;
      req_kind          <= KIND_POLL;
      req_peer_id       <= '0;
      req_counter_value <= '0;
      csr_valid         <= 1'b0;
      csr_index         <= CSR_MY_ID;
      csr_data          <= '0;
      reset             <= 1'b1;

      // Predictor state after reset.
      for (int id = 0; id < ID_SPACE; id++) begin
         seen_counter[id] = '0;
         score[id]        = '0;
         fails[id]        = '0;
         phase[id]        = '0;
      end
      cfg_my_id    = 4'd1;
      cfg_mask     = 16'h0000;
      cfg_interval = 8'd8;
      cfg_limit    = 8'd4;
      cfg_cap      = 8'd8;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].set_regs)
            apply_settings(DIRECTED[i].my_id, DIRECTED[i].mask, DIRECTED[i].interval,
                           DIRECTED[i].limit, DIRECTED[i].cap);
         else
            issue(DIRECTED[i].kind, DIRECTED[i].peer, DIRECTED[i].value,
                  DIRECTED[i].typed, DIRECTED[i].want);
      end

      // Random phase under random settings.
      apply_settings(ID_W'($urandom_range(1, 15)), 16'($urandom),
                     8'($urandom_range(1, 255)), 8'($urandom_range(0, 254)),
                     8'($urandom_range(1, 255)));
      repeat (60) random_transaction(1'b0);

      // Decay storm: failure counts climb toward saturation; a peer above the
      // attempt limit is polled only when its phase comes round to one.
      apply_settings(ID_W'($urandom_range(1, 15)), 16'hFFFF, 8'd255, 8'd254, 8'd255);
      repeat (260) random_transaction(1'b1);

      // The retry interval drops sharply below the phases built up in the
      // storm, which sends polls through the slow phase wrap.
      apply_settings(ID_W'($urandom_range(1, 15)), 16'($urandom),
                     8'($urandom_range(1, 3)), 8'd0, 8'($urandom_range(1, 255)));
      repeat (60) random_transaction(1'b0);

      // Register extremes at the other end.
      apply_settings(4'd1, 16'hFFFF, 8'd1, 8'd0, 8'd1);
      repeat (30) random_transaction(1'b0);
      apply_settings(4'd15, 16'($urandom), 8'd255, 8'd0, 8'd255);
      repeat (30) random_transaction(1'b0);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      while (expected_results.size() != 0)
         report_mismatch($sformatf("result never arrived: %p",
                                   expected_results.pop_front()));
      if (mismatches == 0)
         $display("heartbeat_failure_detector_tb passed");
      else
         $display("heartbeat_failure_detector_tb failed");
      $finish;
   end

endmodule

### filelist.f
rtl/core/hbfd_pkg.sv
rtl/core/hbfd_rem.sv
rtl/core/hbfd_ctrl.sv
rtl/core/hbfd_datapath.sv
rtl/core/heartbeat_failure_detector.sv
tb/heartbeat_failure_detector_tb.sv
